// ----- hdl/kcc_pkg.sv -----
// kcc_pkg: shared types and constants for the key click classifier.
// No dependencies; key_click_classifier, kcc_lane and kcc_merge refer to it by scoped names.

package kcc_pkg;

  localparam int LANES          = 4;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int TIMER_BITS_DEF = 16;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [CFG_W-1:0] POLL_RST     = 16'd30;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd600;
  localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd250;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2,
    PH_REPEAT   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_POLL     = 2'd1,
    REG_LONG     = 2'd2,
    REG_REPEAT   = 2'd3
  } cfg_reg_t;

endpackage

// ----- hdl/kcc_if.sv -----
// kcc_if: valid/ready channel interfaces for button requests and key events.
// Depends on nothing; used by key_click_classifier and its environment.

interface kcc_in_if;
  logic valid;
  logic ready;
  logic button_up;
  logic button_down;
  logic button_ok;
  logic button_esc;

  modport source (output valid, output button_up, output button_down,
                  output button_ok, output button_esc, input ready);
  modport sink   (input valid, input button_up, input button_down,
                  input button_ok, input button_esc, output ready);
endinterface

interface kcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_up;
  logic [1:0] event_down;
  logic [1:0] event_ok;
  logic [1:0] event_esc;

  modport source (output valid, output event_up, output event_down,
                  output event_ok, output event_esc, input ready);
  modport sink   (input valid, input event_up, input event_down,
                  input event_ok, input event_esc, output ready);
endinterface

// ----- hdl/key_click_classifier.sv -----
// key_click_classifier: four-button short/long click qualifier, top level.
// Depends on kcc_pkg, kcc_if, kcc_lane and kcc_merge.
//
//   Channel   Dir  Handshake          Carries
//   in_req    in   valid/ready        button_up, button_down, button_ok, button_esc
//   out_res   out  valid/ready        event_up, event_down, event_ok, event_esc
//   cfg_*     in   cfg_we only        cfg_idx selects register, cfg_data 16 bits
//
// One request per clock while in_req.ready is high; the lanes update in the
// accepting cycle and the result is registered in the output or skid register.
// A skid register keeps in_req.ready high while only the output register is stalled;
// ready drops only when both output and skid registers hold results.
// rst_n is synchronous: lanes go idle, counters clear, registers take defaults.

module key_click_classifier #(
  parameter int TIMER_BITS = kcc_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  kcc_in_if.sink                        in_req,
  kcc_out_if.source                     out_res,
  input  logic                          cfg_we,
  input  logic [kcc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [kcc_pkg::CFG_W-1:0]     cfg_data
);

  // Compare width covers both the register and the counter.
  localparam int WW = (TIMER_BITS > kcc_pkg::CFG_W) ? TIMER_BITS : kcc_pkg::CFG_W;
  localparam logic [WW-1:0] CMAX = WW'({TIMER_BITS{1'b1}});
  localparam logic [WW-1:0] LMAX = CMAX - WW'(1);

  logic [kcc_pkg::CFG_W-1:0] debounce_r, poll_r, long_r, repeat_r;
  logic [WW-1:0]             deb_w, poll_w, long_w, rep_w;
  logic [TIMER_BITS-1:0]     deb_lim, poll_lim, long_lim, rep_lim;

  logic                      acc;
  logic [kcc_pkg::LANES-1:0] pressed;
  kcc_pkg::ev_t              lane_ev [kcc_pkg::LANES];
  kcc_pkg::ev_t              out_ev  [kcc_pkg::LANES];

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= kcc_pkg::DEBOUNCE_RST;
      poll_r     <= kcc_pkg::POLL_RST;
      long_r     <= kcc_pkg::LONG_RST;
      repeat_r   <= kcc_pkg::REPEAT_RST;
    end else if (cfg_we) begin
      unique case (kcc_pkg::cfg_reg_t'(cfg_idx))
        kcc_pkg::REG_DEBOUNCE: debounce_r <= cfg_data;
        kcc_pkg::REG_POLL:     poll_r     <= cfg_data;
        kcc_pkg::REG_LONG:     long_r     <= cfg_data;
        kcc_pkg::REG_REPEAT:   repeat_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp thresholds to what the counters can reach. The long threshold is
  // a strict compare, so it stops one short of the counter maximum.
  assign deb_w    = WW'(debounce_r);
  assign poll_w   = WW'(poll_r);
  assign long_w   = WW'(long_r);
  assign rep_w    = WW'(repeat_r);
  assign deb_lim  = TIMER_BITS'((deb_w  > CMAX) ? CMAX : deb_w);
  assign poll_lim = TIMER_BITS'((poll_w > CMAX) ? CMAX : poll_w);
  assign long_lim = TIMER_BITS'((long_w > LMAX) ? LMAX : long_w);
  assign rep_lim  = TIMER_BITS'((rep_w  > CMAX) ? CMAX : rep_w);

  assign acc     = in_req.valid && in_req.ready;
  assign pressed = {in_req.button_esc, in_req.button_ok,
                    in_req.button_down, in_req.button_up};

  // One lane per button: up, down, ok, escape.
  for (genvar k = 0; k < kcc_pkg::LANES; k++) begin : g_lane
    kcc_lane #(
      .TIMER_BITS (TIMER_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (acc),
      .pressed  (pressed[k]),
      .deb_lim  (deb_lim),
      .poll_lim (poll_lim),
      .long_lim (long_lim),
      .rep_lim  (rep_lim),
      .ev       (lane_ev[k])
    );
  end

  kcc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .lane_ev   (lane_ev),
    .out_ready (out_res.ready),
    .out_valid (out_res.valid),
    .in_ready  (in_req.ready),
    .out_ev    (out_ev)
  );

  assign out_res.event_up   = 2'(out_ev[0]);
  assign out_res.event_down = 2'(out_ev[1]);
  assign out_res.event_ok   = 2'(out_ev[2]);
  assign out_res.event_esc  = 2'(out_ev[3]);

endmodule

// ----- hdl/kcc_lane.sv -----
// kcc_lane: per-button phase machine with saturating interval and hold counters.
// Depends on kcc_pkg.

module kcc_lane #(
  parameter int TIMER_BITS = kcc_pkg::TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  pressed,
  input  logic [TIMER_BITS-1:0] deb_lim,
  input  logic [TIMER_BITS-1:0] poll_lim,
  input  logic [TIMER_BITS-1:0] long_lim,
  input  logic [TIMER_BITS-1:0] rep_lim,
  output kcc_pkg::ev_t          ev
);

  kcc_pkg::phase_t       phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] ic_r, ic_nxt, hc_r, hc_nxt;
  logic [TIMER_BITS-1:0] ic_inc, hc_inc;

  assign ic_inc = (ic_r == '1) ? ic_r : ic_r + 1'b1;
  assign hc_inc = (hc_r == '1) ? hc_r : hc_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    ic_nxt    = ic_inc;
    hc_nxt    = hc_inc;
    ev        = kcc_pkg::EV_NONE;
    unique case (phase_r)
      kcc_pkg::PH_IDLE: begin
        ic_nxt = '0;
        hc_nxt = '0;
        if (pressed) begin
          phase_nxt = kcc_pkg::PH_DEBOUNCE;
        end
      end
      kcc_pkg::PH_DEBOUNCE: begin
        if (ic_inc >= deb_lim) begin
          ic_nxt    = '0;
          phase_nxt = pressed ? kcc_pkg::PH_HELD : kcc_pkg::PH_IDLE;
        end
      end
      kcc_pkg::PH_HELD: begin
        if (ic_inc >= poll_lim) begin
          ic_nxt = '0;
          if (!pressed) begin
            ev        = kcc_pkg::EV_SHORT;
            phase_nxt = kcc_pkg::PH_IDLE;
          end else if (hc_inc > long_lim) begin
            ev        = kcc_pkg::EV_LONG;
            phase_nxt = kcc_pkg::PH_REPEAT;
          end
        end
      end
      kcc_pkg::PH_REPEAT: begin
        if (ic_inc >= rep_lim) begin
          ic_nxt = '0;
          if (pressed) begin
            ev = kcc_pkg::EV_LONG;
          end else begin
            phase_nxt = kcc_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = kcc_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= kcc_pkg::PH_IDLE;
      ic_r    <= '0;
      hc_r    <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      ic_r    <= ic_nxt;
      hc_r    <= hc_nxt;
    end
  end

endmodule

// ----- hdl/kcc_merge.sv -----
// kcc_merge: gathers the lane events into one result and holds it in an
// output register backed by a skid register. Depends on kcc_pkg.

module kcc_merge (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         acc,
  input  kcc_pkg::ev_t lane_ev [kcc_pkg::LANES],
  input  logic         out_ready,
  output logic         out_valid,
  output logic         in_ready,
  output kcc_pkg::ev_t out_ev [kcc_pkg::LANES]
);

  logic         out_valid_r, skid_valid_r;
  kcc_pkg::ev_t out_data_r  [kcc_pkg::LANES];
  kcc_pkg::ev_t skid_data_r [kcc_pkg::LANES];
  logic         pop;

  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = !skid_valid_r;
  assign out_ev    = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (acc) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (acc) begin
      if (!out_valid_r || pop) begin
        out_data_r <= lane_ev;
      end else begin
        skid_data_r <= lane_ev;
      end
    end
  end

endmodule

// ----- hdl/kcc_checker.sv -----
// kcc_checker: port-level assertions for key_click_classifier, bound to it.
// Depends on nothing beyond the ports of the top level.

module kcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_up,
  input logic [1:0] event_down,
  input logic [1:0] event_ok,
  input logic [1:0] event_esc
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_up) &&
      $stable(event_down) && $stable(event_ok) && $stable(event_esc))
    else $error("stalled result changed");

  // No lane ever reports the unused event code.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> event_up != 2'd3 && event_down != 2'd3 &&
      event_ok != 2'd3 && event_esc != 2'd3)
    else $error("undefined event code");

  // A request taken into an empty output stage shows on the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("result missing after request");

  // Backpressure only comes from full output storage.
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("ready low with empty output");

endmodule

bind key_click_classifier kcc_checker u_kcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .event_up   (out_res.event_up),
  .event_down (out_res.event_down),
  .event_ok   (out_res.event_ok),
  .event_esc  (out_res.event_esc)
);
